>>> sv/rai_pkg.sv
// ----------------------------------------------------------------------------
// rai_pkg
// Shared types and constants for the register ALU instruction executor:
// opcodes, sequencer states and the request/response payload structs.
// ----------------------------------------------------------------------------
package rai_pkg;

   // data path and register file geometry
   localparam int DATA_W       = 16;
   localparam int IDX_W        = 3;
   localparam int NUM_REGS_DEF = 8;
   localparam int CNT_W        = $clog2(DATA_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

   // operation codes
   typedef enum logic [2:0] {
      OP_OUT  = 3'd0,
      OP_IN   = 3'd1,
      OP_ADD  = 3'd2,
      OP_MUL  = 3'd3,
      OP_SUB  = 3'd4,
      OP_DIV  = 3'd5,
      OP_LOAD = 3'd6,
      OP_JPOS = 3'd7
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OPER,
      ST_LOOP,
      ST_FIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]               req_type;
      logic [IDX_W-1:0]         dest_reg;
      logic                     operand_is_reg;
      logic [IDX_W-1:0]         src_reg;
      logic signed [DATA_W-1:0] immediate;
      logic signed [DATA_W-1:0] in_value;
   } req_payload_type;

   typedef struct packed {
      logic                     out_valid;
      logic signed [DATA_W-1:0] out_value;
      logic                     branch_taken;
      logic                     div_zero_error;
   } rsp_payload_type;

endpackage

>>> sv/rai_req_if.sv
// ----------------------------------------------------------------------------
// rai_req_if
// Request channel: valid/ready handshake carrying one decoded instruction.
// ----------------------------------------------------------------------------
interface rai_req_if;
   import rai_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

>>> sv/rai_rsp_if.sv
// ----------------------------------------------------------------------------
// rai_rsp_if
// Response channel: valid/ready handshake carrying one execution result.
// ----------------------------------------------------------------------------
interface rai_rsp_if;
   import rai_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

>>> sv/rai_ram.sv
// ----------------------------------------------------------------------------
// rai_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rai_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> sv/register_alu_instruction_executor.sv
// ----------------------------------------------------------------------------
// register_alu_instruction_executor
// Executes one decoded instruction per request against a signed register
// file, using one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: OUT, IN, ADD, SUB, LOAD, JPOS and DIV by zero go from the accept
//   through the execute state to the response; MUL and DIV with a nonzero
//   divisor also run the bit-per-cycle loop through the shared 17-bit adder
//   and a final write-back state before the response.
// Flow: one request at a time; the next request can be taken in the cycle
//   after the response is taken.
// Reset: synchronous; registers read back as index plus one until written.
// ----------------------------------------------------------------------------
module register_alu_instruction_executor #(
   parameter int NUM_REGS = rai_pkg::NUM_REGS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rai_req_if.sink    req_chan,
   rai_rsp_if.source  rsp_chan
);
   import rai_pkg::*;

   localparam int AW = $clog2(NUM_REGS);

   state_type                state_ff, state_in;
   req_payload_type          req_ff, req_in;
   rsp_payload_type          rsp_ff, rsp_in;
   logic                     x_inr_ff, x_inr_in;
   logic                     y_inr_ff, y_inr_in;
   logic                     x_vld_ff, x_vld_in;
   logic                     y_vld_ff, y_vld_in;
   logic [NUM_REGS-1:0]      valid_ff;
   logic [DATA_W-1:0]        acc_ff, acc_in;
   logic [DATA_W-1:0]        opa_ff, opa_in;
   logic [DATA_W-1:0]        opb_ff, opb_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;

   logic                     accept;
   logic [AW-1:0]            rd_addr_a;
   logic [AW-1:0]            rd_addr_b;
   logic [DATA_W-1:0]        ram_a;
   logic [DATA_W-1:0]        ram_b;
   logic signed [DATA_W-1:0] x_val;
   logic signed [DATA_W-1:0] y_reg;
   logic signed [DATA_W-1:0] y_val;
   logic                     wr_req;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [DATA_W:0]          add_a;
   logic [DATA_W:0]          add_b;
   logic                     add_sub;
   logic [DATA_W+1:0]        add_sum;
   logic                     add_ge;
   op_type                   op;

   // handshake
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = (state_ff == ST_RESP);
   assign rsp_chan.payload = rsp_ff;

   // register file reads issued on request accept
   assign rd_addr_a = AW'(req_chan.payload.dest_reg);
   assign rd_addr_b = AW'(req_chan.payload.src_reg);

   rai_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // operand selection: out of range reads zero, unwritten reads reset value
   always_comb begin
      if (!x_inr_ff) begin
         x_val = '0;
      end else if (x_vld_ff) begin
         x_val = ram_a;
      end else begin
         x_val = DATA_W'(req_ff.dest_reg) + DATA_W'(1);
      end
      if (!y_inr_ff) begin
         y_reg = '0;
      end else if (y_vld_ff) begin
         y_reg = ram_b;
      end else begin
         y_reg = DATA_W'(req_ff.src_reg) + DATA_W'(1);
      end
      y_val = req_ff.operand_is_reg ? y_reg : req_ff.immediate;
   end

   // shared adder operands, chosen by state and operation
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      case (state_ff)
         ST_OPER: begin
            if (op == OP_ADD || op == OP_SUB) begin
               add_a   = {x_val[DATA_W-1], x_val};
               add_b   = {y_val[DATA_W-1], y_val};
               add_sub = (op == OP_SUB);
            end
         end

         ST_LOOP: begin
            if (op == OP_MUL) begin
               add_a = {1'b0, acc_ff};
               add_b = {1'b0, opa_ff};
            end else begin
               add_a   = {acc_ff, opa_ff[DATA_W-1]};
               add_b   = {1'b0, opb_ff};
               add_sub = 1'b1;
            end
         end

         ST_FIN: begin
            // product as is, quotient negated when signs differ
            if (op == OP_MUL) begin
               add_a = {1'b0, acc_ff};
            end else begin
               add_b   = {1'b0, opa_ff};
               add_sub = neg_ff;
            end
         end

         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   // shared adder / subtractor; top bit is the no-borrow flag
   assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                    + (DATA_W+2)'(add_sub);
   assign add_ge  = add_sum[DATA_W+1];

   assign op      = op_type'(req_ff.req_type);
   assign wr_en   = wr_req && x_inr_ff;
   assign wr_addr = AW'(req_ff.dest_reg);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // valid bits of the register file
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      x_inr_ff <= x_inr_in;
      y_inr_ff <= y_inr_in;
      x_vld_ff <= x_vld_in;
      y_vld_ff <= y_vld_in;
      acc_ff   <= acc_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      x_inr_in = x_inr_ff;
      y_inr_in = y_inr_ff;
      x_vld_in = x_vld_ff;
      y_vld_in = y_vld_ff;
      acc_in   = acc_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      wr_req   = 1'b0;
      wr_data  = add_sum[DATA_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_chan.payload;
               rsp_in   = '0;
               x_inr_in = int'(req_chan.payload.dest_reg) < NUM_REGS;
               y_inr_in = int'(req_chan.payload.src_reg) < NUM_REGS;
               x_vld_in = x_inr_in && valid_ff[rd_addr_a];
               y_vld_in = y_inr_in && valid_ff[rd_addr_b];
               state_in = ST_OPER;
            end
         end

         ST_OPER: begin
            state_in = ST_RESP;
            case (op)
               OP_OUT: begin
                  rsp_in.out_valid = 1'b1;
                  rsp_in.out_value = x_val;
               end
               OP_IN: begin
                  wr_req  = 1'b1;
                  wr_data = req_ff.in_value;
               end
               OP_ADD, OP_SUB: begin
                  wr_req  = 1'b1;
               end
               OP_LOAD: begin
                  wr_req  = 1'b1;
                  wr_data = y_val;
               end
               OP_JPOS: begin
                  rsp_in.branch_taken = !x_val[DATA_W-1] && (x_val != '0);
               end
               OP_MUL: begin
                  acc_in   = '0;
                  opa_in   = x_val;
                  opb_in   = y_val;
                  cnt_in   = '0;
                  state_in = ST_LOOP;
               end
               OP_DIV: begin
                  if (y_val == '0) begin
                     rsp_in.div_zero_error = 1'b1;
                  end else begin
                     acc_in   = '0;
                     opa_in   = x_val[DATA_W-1] ? (~x_val + 1'b1) : x_val;
                     opb_in   = y_val[DATA_W-1] ? (~y_val + 1'b1) : y_val;
                     neg_in   = x_val[DATA_W-1] ^ y_val[DATA_W-1];
                     cnt_in   = '0;
                     state_in = ST_LOOP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end

         ST_LOOP: begin
            if (op == OP_MUL) begin
               // shift-add: one multiplier bit per cycle
               if (opb_ff[0]) begin
                  acc_in = add_sum[DATA_W-1:0];
               end
               opa_in = {opa_ff[DATA_W-2:0], 1'b0};
               opb_in = {1'b0, opb_ff[DATA_W-1:1]};
            end else begin
               // restoring divide: one quotient bit per cycle
               acc_in  = add_ge ? add_sum[DATA_W-1:0] : add_a[DATA_W-1:0];
               opa_in  = {opa_ff[DATA_W-2:0], add_ge};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            // write back the adder output
            wr_req   = 1'b1;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // checks
   a_accept_to_oper: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_OPER)
      else $error("request accept did not start execution");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_OPER || state_ff == ST_FIN))
      else $error("register write outside execute states");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $onehot0({rsp_ff.out_valid, rsp_ff.branch_taken,
                                   rsp_ff.div_zero_error}))
      else $error("more than one response flag raised");

   a_value_only_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_ff.out_valid) |-> rsp_ff.out_value == '0)
      else $error("response value nonzero without out_valid");

   a_loop_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP && cnt_ff == CNT_LAST) |=> state_ff == ST_FIN)
      else $error("iteration loop did not end after full count");

endmodule
